[sv/witd_pkg.sv]
// Shared constants, widths and state type of the wide integer to decimal unit.
package witd_pkg;

  // Capacity in bytes of one number
  localparam int MAX_BYTES = 16;
  // Width of the magnitude shift register
  localparam int MAG_W = MAX_BYTES * 8;
  // Decimal digits needed for MAG_W bits: floor(MAG_W * log10(2)) + 1
  localparam int NDIG = ((MAG_W * 1233) >> 12) + 1;
  localparam int BCD_W = NDIG * 4;
  // Most characters emitted for one number
  localparam int OUT_LIMIT = 40;

  localparam int BYTE_W = 8;
  localparam int CHAR_W = 6;
  localparam int HELD_W = $clog2(MAX_BYTES + 1);
  localparam int BIT_CNT_W = (MAG_W > 1) ? $clog2(MAG_W) : 1;
  localparam int DIG_CNT_W = $clog2(NDIG + 1);
  localparam int EMIT_W = $clog2(OUT_LIMIT + 1);

  // ASCII codes, cut to the output width
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_NEG,
    ST_DABBLE,
    ST_SKIP,
    ST_EMIT
  } witd_state_t;

endpackage

[sv/witd_in_if.sv]
// Input channel: one byte of a wide integer per item.
interface witd_in_if import witd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              is_signed;
  logic              last_byte;

  modport source (output valid, output byte_value, output is_signed, output last_byte,
                  input ready);
  modport sink (input valid, input byte_value, input is_signed, input last_byte,
                output ready);
endinterface

[sv/witd_out_if.sv]
// Output channel: one ASCII character of the decimal text per item.
interface witd_out_if import witd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  logic              overflow;

  modport source (output valid, output char_code, output last_char, output overflow,
                  input ready);
  modport sink (input valid, input char_code, input last_char, input overflow,
                output ready);
endinterface

[sv/wide_int_to_decimal_unit.sv]
// Wide integer to ASCII decimal converter, bit-serial double dabble.
//
// in_if takes one byte per item, most significant byte first; is_signed is
// sampled on the first byte of a number, last_byte marks its final byte.
// Bytes past MAX_BYTES are dropped and every character of that number then
// carries overflow. out_if gives one ASCII character per item: a minus sign
// for a negative number, then the digits from most significant down, with
// last_char on the final one (at most OUT_LIMIT characters).
// Bytes load at one per cycle. After the last byte, a negative number is
// negated by serial two's-complement over the magnitude shift register
// (MAG_W bits, 128 for 16 bytes), then every number goes through double
// dabble, one bit per cycle, and leading zeros are stripped from the NDIG
// (39) digit positions to present the first character.
// Characters then leave at one per cycle while out_if.ready is high; a stall
// holds the current character. in_if.ready is low from the last byte until
// the final character is taken. Reset (rst_n low, synchronous) returns the
// block to waiting for the first byte of a new number.
module wide_int_to_decimal_unit import witd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  witd_in_if.sink   in_if,
  witd_out_if.source out_if
);

  witd_state_t          state_r, state_nxt;
  logic [HELD_W-1:0]    bytes_held_r, bytes_held_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 neg_r, neg_nxt;
  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic                 carry_r, carry_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [DIG_CNT_W-1:0] dig_left_r, dig_left_nxt;
  logic [EMIT_W-1:0]    emit_cnt_r, emit_cnt_nxt;
  logic                 minus_pend_r, minus_pend_nxt;

  logic                 in_fire;
  logic                 out_fire;
  logic                 first_byte;
  logic                 fill;
  logic [BCD_W-1:0]     bcd_adj;
  logic [3:0]           top_digit;
  logic                 out_last;

  // Handshake and output payload
  assign in_if.ready      = (state_r == ST_LOAD);
  assign in_fire          = in_if.valid && in_if.ready;
  assign out_if.valid     = (state_r == ST_EMIT);
  assign out_fire         = out_if.valid && out_if.ready;
  assign top_digit        = bcd_r[BCD_W-1 -: 4];
  assign out_last         = ((dig_left_r == DIG_CNT_W'(1)) && !minus_pend_r)
                            || (emit_cnt_r == EMIT_W'(OUT_LIMIT - 1));
  assign out_if.char_code = minus_pend_r ? CHAR_MINUS : (CHAR_ZERO + {2'b00, top_digit});
  assign out_if.last_char = out_last;
  assign out_if.overflow  = ovf_r;

  // A new number starts when nothing is held and nothing was dropped
  assign first_byte = (bytes_held_r == '0) && !ovf_r;
  // Sign extension of the first byte over the whole register
  assign fill       = in_if.is_signed && in_if.byte_value[BYTE_W-1];

  // Double dabble correction: add three to every digit of five or more
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*4 +: 4] >= 4'd5) begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4];
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      bytes_held_r <= '0;
      ovf_r        <= 1'b0;
      neg_r        <= 1'b0;
      carry_r      <= 1'b0;
      bit_cnt_r    <= '0;
      dig_left_r   <= '0;
      emit_cnt_r   <= '0;
      minus_pend_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bytes_held_r <= bytes_held_nxt;
      ovf_r        <= ovf_nxt;
      neg_r        <= neg_nxt;
      carry_r      <= carry_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      dig_left_r   <= dig_left_nxt;
      emit_cnt_r   <= emit_cnt_nxt;
      minus_pend_r <= minus_pend_nxt;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    bytes_held_nxt = bytes_held_r;
    ovf_nxt        = ovf_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    carry_nxt      = carry_r;
    bit_cnt_nxt    = bit_cnt_r;
    bcd_nxt        = bcd_r;
    dig_left_nxt   = dig_left_r;
    emit_cnt_nxt   = emit_cnt_r;
    minus_pend_nxt = minus_pend_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          priority if (first_byte) begin
            neg_nxt        = fill;
            mag_nxt        = ({MAG_W{fill}} << BYTE_W) | MAG_W'(in_if.byte_value);
            bytes_held_nxt = HELD_W'(1);
          end else if (bytes_held_r < HELD_W'(MAX_BYTES)) begin
            mag_nxt        = (mag_r << BYTE_W) | MAG_W'(in_if.byte_value);
            bytes_held_nxt = bytes_held_r + HELD_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_if.last_byte) begin
            bit_cnt_nxt = BIT_CNT_W'(MAG_W - 1);
            carry_nxt   = 1'b1;
            bcd_nxt     = '0;
            state_nxt   = neg_nxt ? ST_NEG : ST_DABBLE;
          end
        end
      end

      // Serial negate, least significant bit first, rotating right
      ST_NEG: begin
        mag_nxt     = {~mag_r[0] ^ carry_r, mag_r[MAG_W-1:1]};
        carry_nxt   = ~mag_r[0] & carry_r;
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        if (bit_cnt_r == '0) begin
          bit_cnt_nxt = BIT_CNT_W'(MAG_W - 1);
          state_nxt   = ST_DABBLE;
        end
      end

      // One magnitude bit into the BCD register per cycle
      ST_DABBLE: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], mag_r[MAG_W-1]};
        mag_nxt     = mag_r << 1;
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        if (bit_cnt_r == '0) begin
          dig_left_nxt = DIG_CNT_W'(NDIG);
          state_nxt    = ST_SKIP;
        end
      end

      // Drop leading zeros, keeping at least one digit
      ST_SKIP: begin
        if ((top_digit == 4'd0) && (dig_left_r > DIG_CNT_W'(1))) begin
          bcd_nxt      = bcd_r << 4;
          dig_left_nxt = dig_left_r - DIG_CNT_W'(1);
        end else begin
          minus_pend_nxt = neg_r;
          emit_cnt_nxt   = '0;
          state_nxt      = ST_EMIT;
        end
      end

      // One character per accepted item
      ST_EMIT: begin
        if (out_fire) begin
          emit_cnt_nxt = emit_cnt_r + EMIT_W'(1);
          if (out_last) begin
            bytes_held_nxt = '0;
            ovf_nxt        = 1'b0;
            minus_pend_nxt = 1'b0;
            state_nxt      = ST_LOAD;
          end else if (minus_pend_r) begin
            minus_pend_nxt = 1'b0;
          end else begin
            bcd_nxt      = bcd_r << 4;
            dig_left_nxt = dig_left_r - DIG_CNT_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule
